// File: rtl/orct_pkg.sv
package orct_pkg;

  localparam int unsigned MaxObstacles = 64;
  localparam int unsigned IdxW = $clog2(MaxObstacles);
  localparam int unsigned CntW = $clog2(MaxObstacles + 1);

  // entry word: id, left, top, wide, tall, value
  localparam int unsigned EntryW = 88;

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_SET    = 3'd2,
    KIND_MOVE   = 3'd3,
    KIND_POINT  = 3'd4,
    KIND_AREA   = 3'd5
  } kind_e;

  typedef struct packed {
    logic signed [15:0] id;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] wide;
    logic signed [15:0] tall;
    logic [7:0]         value;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic [7:0] hit_value;
    logic table_full;
  } result_t;

  function automatic logic within16(logic signed [15:0] v, logic signed [15:0] lo,
                                    logic signed [15:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic logic spans_meet(logic signed [15:0] a1, logic signed [15:0] a2,
                                      logic signed [15:0] b1, logic signed [15:0] b2);
    return within16(b1, a1, a2) || within16(b2, a1, a2) ||
           within16(a1, b1, b2) || within16(a2, b1, b2);
  endfunction

endpackage

// File: rtl/orct_ram.sv
module orct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/orct_test.sv
module orct_test (
  input  orct_pkg::kind_e  kind_i,
  input  orct_pkg::entry_t ent_i,
  input  orct_pkg::entry_t req_i,
  output logic             id_match_o,
  output logic             id_less_o,
  output logic             collide_o,
  output orct_pkg::entry_t moved_o
);
  import orct_pkg::*;

  logic signed [15:0] r_edge, b_edge, x2, y2;

  // shared compare unit, one table entry per use
  always_comb begin
    r_edge     = ent_i.left + ent_i.wide;
    b_edge     = ent_i.top + ent_i.tall;
    x2         = req_i.left + req_i.wide;
    y2         = req_i.top + req_i.tall;
    id_match_o = (ent_i.id == req_i.id);
    id_less_o  = (ent_i.id < req_i.id);
    if (kind_i == KIND_POINT) begin
      collide_o = within16(req_i.left, ent_i.left, r_edge) &&
                  within16(req_i.top, ent_i.top, b_edge);
    end else begin
      collide_o = spans_meet(req_i.left, x2, ent_i.left, r_edge) &&
                  spans_meet(req_i.top, y2, ent_i.top, b_edge);
    end
    moved_o = ent_i;
    if (kind_i == KIND_SET) begin
      moved_o.value = req_i.value;
    end else begin
      moved_o.left = ent_i.left + req_i.left;
      moved_o.top  = ent_i.top + req_i.top;
    end
  end

endmodule

// File: rtl/obstacle_rect_collision_table_unit.sv
// obstacle rectangle collision table
// s_axis: one operation per transfer; tdata packs kind, obstacle_id, x_pos,
// y_pos, width, height, new_value from bit 0 up (91 bits, zero filled to 96).
// m_axis: one result per operation; tdata packs hit, hit_value, table_full.
// default_value_we_i/default_value_i load the default query value; write
// only while idle.
// each operation walks the entry memory through one shared compare unit,
// one entry at a time (address, registered read, then test or write).
// insert shifts entries up from the top, delete compacts downward.
// delete, set, move and a missed query walk every entry; an insert walks
// down from the top until its slot is found; a refused insert or an unused
// kind goes straight to the result. queries stop at the first hit. the
// table is in one ram, read and written one entry a time.
// s_axis_tready is low while an operation runs or a result waits.
// m_axis holds its result until taken; a stalled receiver blocks new input.
// reset empties the table (count to zero) and clears default_value; entry
// contents need no clearing since only entries below the count are read.
module obstacle_rect_collision_table_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // kind, obstacle_id, x_pos, y_pos, width, height, new_value
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [15:0]  m_axis_tdata,   // hit, hit_value, table_full
  input  logic         default_value_we_i,
  input  logic [7:0]   default_value_i
);
  import orct_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_EVAL  = 5'b00100,
    ST_PUT   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  kind_e kind_q, kind_d;
  entry_t req_q, req_d;
  logic [CntW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d;
  logic [7:0] dflt_q;
  result_t res_q, res_d;
  logic [2:0] raw_kind;

  logic we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t wdata, rdata;
  logic id_match, id_less, collide;
  entry_t moved;

  orct_ram #(.Width(EntryW), .Depth(MaxObstacles)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  orct_test u_test (
    .kind_i(kind_q), .ent_i(rdata), .req_i(req_q), .id_match_o(id_match),
    .id_less_o(id_less), .collide_o(collide), .moved_o(moved)
  );

  assign raw_kind      = s_axis_tdata[2:0];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {6'd0, res_q.table_full, res_q.hit_value, res_q.hit};

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    req_d   = req_q;
    cnt_d   = cnt_q;
    i_d     = i_q;
    j_d     = j_q;
    res_d   = res_q;
    we      = 1'b0;
    waddr   = j_q[IdxW-1:0];
    wdata   = moved;
    raddr   = i_q[IdxW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          kind_d = kind_e'(raw_kind);
          req_d  = '{id: s_axis_tdata[18:3], left: s_axis_tdata[34:19],
                     top: s_axis_tdata[50:35], wide: s_axis_tdata[66:51],
                     tall: s_axis_tdata[82:67], value: s_axis_tdata[90:83]};
          res_d  = '0;
          i_d    = '0;
          j_d    = '0;
          state_d = ST_READ;
          if (raw_kind == KIND_POINT || raw_kind == KIND_AREA) begin
            res_d.hit_value = dflt_q;
          end
          if (raw_kind == KIND_INSERT) begin
            if (cnt_q >= CntW'(MaxObstacles)) begin
              res_d.table_full = 1'b1;
              state_d = ST_OUT;
            end else begin
              // walk down from the top: i reads entry below, j is the hole
              i_d = cnt_q - 1'b1;
              j_d = cnt_q;
            end
          end else if (raw_kind > KIND_AREA) begin
            state_d = ST_OUT;
          end
        end
      end
      ST_READ: begin
        if (kind_q == KIND_INSERT) begin
          state_d = (j_q == '0) ? ST_PUT : ST_EVAL;
        end else begin
          state_d = (i_q >= cnt_q) ? ST_OUT : ST_EVAL;
          if (i_q >= cnt_q && kind_q == KIND_DELETE) begin
            cnt_d = j_q;
          end
        end
      end
      ST_EVAL: begin
        state_d = ST_READ;
        case (kind_q) inside
          KIND_INSERT: begin
            if (id_less) begin
              state_d = ST_PUT;
            end else begin
              we    = 1'b1;
              wdata = rdata;
              j_d   = j_q - 1'b1;
              i_d   = i_q - 1'b1;
            end
          end
          KIND_DELETE: begin
            if (id_match) begin
              res_d.hit = 1'b1;
            end else begin
              we    = 1'b1;
              wdata = rdata;
              j_d   = j_q + 1'b1;
            end
            i_d = i_q + 1'b1;
          end
          KIND_SET, KIND_MOVE: begin
            if (id_match) begin
              res_d.hit = 1'b1;
              we    = 1'b1;
              waddr = i_q[IdxW-1:0];
            end
            i_d = i_q + 1'b1;
          end
          default: begin
            if (collide) begin
              res_d.hit       = 1'b1;
              res_d.hit_value = rdata.value;
              state_d = ST_OUT;
            end
            i_d = i_q + 1'b1;
          end
        endcase
      end
      ST_PUT: begin
        we      = 1'b1;
        wdata   = req_q;
        cnt_d   = cnt_q + 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      dflt_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (default_value_we_i) begin
        dflt_q <= default_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    req_q  <= req_d;
    i_q    <= i_d;
    j_q    <= j_d;
    res_q  <= res_d;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxObstacles)) else $error("entry count over capacity");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_no_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
  a_full_only_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[9] |-> !m_axis_tdata[0])
    else $error("full flag with hit");
`endif

endmodule
